[rtl/core/cgc_pkg.sv]
// ----------------------------------------------------------------------------
// cgc_pkg
// Shared types, constants and helper functions of the circle collision unit.
// ----------------------------------------------------------------------------
package cgc_pkg;

	// Field widths
	localparam int POS_W  = 24;
	localparam int RAD_W  = 16;
	localparam int CODE_W = 8;
	localparam int SLOT_W = 12;
	localparam int MARG_W = 8;
	localparam int CNT_W  = 7;

	// Tile edge is 1.0 in Q.8, so a tile index is a coordinate shifted down
	localparam int TILE_SHIFT = 8;

	// Arithmetic widths
	localparam int BND_W  = 26;                  // x +/- r +/- margin
	localparam int QT_W   = BND_W - TILE_SHIFT;  // tile coordinate of a bound
	localparam int DIFF_W = 25;                  // signed distance component
	localparam int MAG_W  = 24;                  // magnitude of a distance component
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int RR_W   = 2 * RAD_W;
	localparam int MD_W   = RAD_W + 1;
	localparam int THR_W  = 2 * MD_W;

	// Item modes
	localparam logic [1:0] MODE_QUERY  = 2'd0;
	localparam logic [1:0] MODE_TILE   = 2'd1;
	localparam logic [1:0] MODE_ENTITY = 2'd2;

	// Register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WALL_CODE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_CODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENT_COUNT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 3'd5;

	// Configuration seen by the query engine
	typedef struct packed {
		logic [CNT_W-1:0]  map_width;
		logic [CNT_W-1:0]  map_height;
		logic [CODE_W-1:0] wall_code;
		logic [CODE_W-1:0] door_code;
		logic [CNT_W-1:0]  entity_count;
		logic [MARG_W-1:0] box_pad;
	} cfg_t;

	// One entity table entry
	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [RAD_W-1:0]        rad;
		logic                    active;
		logic                    solid;
	} ent_t;

	// Divide a bound by the tile size, truncating toward zero
	function automatic logic signed [QT_W-1:0] tile_of(input logic signed [BND_W-1:0] v);
		logic signed [BND_W-1:0] biased;
		biased = v + $signed({{(BND_W-TILE_SHIFT){1'b0}}, {TILE_SHIFT{v[BND_W-1]}}});
		return biased[BND_W-1:TILE_SHIFT];
	endfunction

	// Clamp a point into a closed interval
	function automatic logic signed [DIFF_W-1:0] nearest(input logic signed [DIFF_W-1:0] p,
		input logic signed [DIFF_W-1:0] lo, input logic signed [DIFF_W-1:0] hi);
		logic signed [DIFF_W-1:0] r;
		r = p;
		if (p < lo) r = lo;
		if (p > hi) r = hi;
		return r;
	endfunction

	// Magnitude of a signed distance component
	function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
		logic signed [DIFF_W-1:0] n;
		n = d[DIFF_W-1] ? -d : d;
		return n[MAG_W-1:0];
	endfunction

endpackage

[rtl/core/cgc_tile_mem.sv]
// ----------------------------------------------------------------------------
// cgc_tile_mem
// Tile code memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cgc_tile_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [cgc_pkg::CODE_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [cgc_pkg::CODE_W-1:0] rdata
);

	logic [cgc_pkg::CODE_W-1:0] mem_q [DEPTH];

	// Write on request, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/cgc_ent_mem.sv]
// ----------------------------------------------------------------------------
// cgc_ent_mem
// Entity table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cgc_ent_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  cgc_pkg::ent_t        wdata,
	input  logic [AW-1:0]        raddr,
	output cgc_pkg::ent_t        rdata
);

	cgc_pkg::ent_t mem_q [DEPTH];

	// Write on request, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/cgc_query.sv]
// ----------------------------------------------------------------------------
// cgc_query
// Query sequencer: walks the tile search box and the entity slots, one
// memory read a cycle, through a shared distance and compare pipeline.
// ----------------------------------------------------------------------------
module cgc_query #(
	parameter int MAP_DIM_MAX      = 64,
	parameter int MAX_ENTITY_SLOTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cgc_pkg::cfg_t                     cfg,
	input  logic                              start,
	input  logic signed [cgc_pkg::POS_W-1:0]  qx,
	input  logic signed [cgc_pkg::POS_W-1:0]  qy,
	input  logic [cgc_pkg::RAD_W-1:0]         qr,
	output logic                              busy,
	output logic                              done,
	output logic                              hit,
	input  logic                              ack,
	output logic [$clog2(MAP_DIM_MAX*MAP_DIM_MAX)-1:0] tile_raddr,
	input  logic [cgc_pkg::CODE_W-1:0]        tile_rdata,
	output logic [((MAX_ENTITY_SLOTS > 1) ? $clog2(MAX_ENTITY_SLOTS) : 1)-1:0] ent_raddr,
	input  cgc_pkg::ent_t                     ent_rdata
);

	localparam int TA_W  = $clog2(MAP_DIM_MAX * MAP_DIM_MAX);
	localparam int IDX_W = $clog2(MAP_DIM_MAX);
	localparam int DIM_W = $clog2(MAP_DIM_MAX + 1);
	localparam int EA_W  = (MAX_ENTITY_SLOTS > 1) ? $clog2(MAX_ENTITY_SLOTS) : 1;
	localparam int EC_W  = $clog2(MAX_ENTITY_SLOTS + 1);
	localparam int SAT_W = 9;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SET1  = 8'b0000_0010,
		S_SET2  = 8'b0000_0100,
		S_SET3  = 8'b0000_1000,
		S_SET4  = 8'b0001_0000,
		S_TILE  = 8'b0010_0000,
		S_ENT   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic   drain_q;

	// Query operands and derived bounds
	logic signed [cgc_pkg::POS_W-1:0] x_q, y_q;
	logic [cgc_pkg::RAD_W-1:0]        r_q;
	logic [cgc_pkg::RR_W-1:0]         rr_q;
	logic [DIM_W-1:0]                 wsat_q;
	logic [EC_W-1:0]                  nsat_q;
	logic signed [cgc_pkg::BND_W-1:0] vx0_q, vx1_q, vy0_q, vy1_q;
	logic signed [cgc_pkg::QT_W-1:0]  qx0_q, qx1_q, qy0_q, qy1_q;
	logic [IDX_W-1:0]                 x0_q, x1_q, y0_q, y1_q;
	logic                             tile_go_q;

	// Scan counters
	logic [IDX_W-1:0] cx_q, cy_q;
	logic [TA_W-1:0]  row_base_q;
	logic [EC_W-1:0]  ei_q;
	logic             hit_q;

	// Pipeline
	logic                              v_s1, v_s2, v_s3;
	logic                              ent_s1;
	logic [IDX_W-1:0]                  cx_s1, cy_s1;
	logic [cgc_pkg::MAG_W-1:0]         dxa_s2, dya_s2;
	logic [cgc_pkg::MD_W-1:0]          md_s2;
	logic                              use_md_s2;
	logic [cgc_pkg::SQ_W-1:0]          dx2_s3, dy2_s3;
	logic [cgc_pkg::THR_W-1:0]         thr_s3;

	logic issue_t, issue_e;

	// Combinational bounds and distance terms
	logic [SAT_W-1:0]                  w9, n9;
	logic signed [cgc_pkg::BND_W-1:0]  xs26, ys26, rm26;
	logic signed [cgc_pkg::QT_W-1:0]   lox, hix, loy, hiy, wm1, hm1;
	logic [SAT_W-1:0]                  h9;
	logic signed [cgc_pkg::DIFF_W-1:0] xs25, ys25, lox25, hix25, loy25, hiy25;
	logic signed [cgc_pkg::DIFF_W-1:0] dxt, dyt, dxe, dye;
	logic                              able;
	logic [cgc_pkg::SUM_W-1:0]         dsum;

	assign issue_t = (state_q == S_TILE);
	assign issue_e = (state_q == S_ENT) && (nsat_q != '0);

	assign tile_raddr = row_base_q + TA_W'(cx_q);
	assign ent_raddr  = EA_W'(ei_q);

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign hit  = hit_q;

	// Saturate map size and entity count, widen operands
	always_comb begin
		w9   = SAT_W'(cfg.map_width);
		h9   = SAT_W'(cfg.map_height);
		n9   = SAT_W'(cfg.entity_count);
		if (w9 > SAT_W'(MAP_DIM_MAX)) w9 = SAT_W'(MAP_DIM_MAX);
		if (h9 > SAT_W'(MAP_DIM_MAX)) h9 = SAT_W'(MAP_DIM_MAX);
		if (n9 > SAT_W'(MAX_ENTITY_SLOTS)) n9 = SAT_W'(MAX_ENTITY_SLOTS);
		xs26 = cgc_pkg::BND_W'(x_q);
		ys26 = cgc_pkg::BND_W'(y_q);
		rm26 = $signed(cgc_pkg::BND_W'(r_q) + cgc_pkg::BND_W'(cfg.box_pad));
	end

	// Clamp the tile range to the map
	always_comb begin
		wm1 = $signed(cgc_pkg::QT_W'(wsat_q)) - $signed(cgc_pkg::QT_W'(1));
		hm1 = $signed(cgc_pkg::QT_W'(h9)) - $signed(cgc_pkg::QT_W'(1));
		lox = (qx0_q < 0) ? '0 : qx0_q;
		loy = (qy0_q < 0) ? '0 : qy0_q;
		hix = (qx1_q > wm1) ? wm1 : qx1_q;
		hiy = (qy1_q > hm1) ? hm1 : qy1_q;
	end

	// Distance from the centre to a tile rectangle or an entity
	always_comb begin
		xs25  = cgc_pkg::DIFF_W'(x_q);
		ys25  = cgc_pkg::DIFF_W'(y_q);
		lox25 = $signed(cgc_pkg::DIFF_W'(cx_s1) << cgc_pkg::TILE_SHIFT);
		hix25 = $signed((cgc_pkg::DIFF_W'(cx_s1) + 1'b1) << cgc_pkg::TILE_SHIFT);
		loy25 = $signed(cgc_pkg::DIFF_W'(cy_s1) << cgc_pkg::TILE_SHIFT);
		hiy25 = $signed((cgc_pkg::DIFF_W'(cy_s1) + 1'b1) << cgc_pkg::TILE_SHIFT);
		dxt   = xs25 - cgc_pkg::nearest(xs25, lox25, hix25);
		dyt   = ys25 - cgc_pkg::nearest(ys25, loy25, hiy25);
		dxe   = xs25 - cgc_pkg::DIFF_W'(ent_rdata.x);
		dye   = ys25 - cgc_pkg::DIFF_W'(ent_rdata.y);
		if (ent_s1) begin
			able = ent_rdata.active && ent_rdata.solid;
		end else begin
			able = (tile_rdata == cfg.wall_code) || (tile_rdata == cfg.door_code);
		end
		dsum = cgc_pkg::SUM_W'(dx2_s3) + cgc_pkg::SUM_W'(dy2_s3);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_SET1;
				end
				S_SET1: state_q <= S_SET2;
				S_SET2: state_q <= S_SET3;
				S_SET3: state_q <= S_SET4;
				S_SET4: state_q <= tile_go_q ? S_TILE : S_ENT;
				S_TILE: begin
					if (cx_q == x1_q && cy_q == y1_q) state_q <= S_ENT;
				end
				S_ENT: begin
					if (!drain_q) begin
						if (nsat_q == '0 || ei_q == nsat_q - 1'b1) drain_q <= 1'b1;
					end else if (!(v_s1 || v_s2 || v_s3)) begin
						drain_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (ack) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture operands, work out the search box, advance the scan
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			x_q <= qx;
			y_q <= qy;
			r_q <= qr;
		end
		if (state_q == S_SET1) begin
			vx0_q  <= xs26 - rm26;
			vx1_q  <= xs26 + rm26;
			vy0_q  <= ys26 - rm26;
			vy1_q  <= ys26 + rm26;
			rr_q   <= r_q * r_q;
			wsat_q <= DIM_W'(w9);
			nsat_q <= EC_W'(n9);
		end
		if (state_q == S_SET2) begin
			qx0_q <= cgc_pkg::tile_of(vx0_q);
			qx1_q <= cgc_pkg::tile_of(vx1_q);
			qy0_q <= cgc_pkg::tile_of(vy0_q);
			qy1_q <= cgc_pkg::tile_of(vy1_q);
		end
		if (state_q == S_SET3) begin
			x0_q      <= IDX_W'(lox);
			x1_q      <= IDX_W'(hix);
			y0_q      <= IDX_W'(loy);
			y1_q      <= IDX_W'(hiy);
			tile_go_q <= (lox <= hix) && (loy <= hiy);
		end
		if (state_q == S_SET4) begin
			row_base_q <= TA_W'(y0_q) * TA_W'(wsat_q);
			cx_q       <= x0_q;
			cy_q       <= y0_q;
			ei_q       <= '0;
		end
		if (issue_t) begin
			if (cx_q == x1_q) begin
				cx_q       <= x0_q;
				cy_q       <= cy_q + 1'b1;
				row_base_q <= row_base_q + TA_W'(wsat_q);
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
		if (issue_e && !drain_q) begin
			ei_q <= ei_q + 1'b1;
		end
	end

	// Pipeline valids and the hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			v_s1 <= issue_t || (issue_e && !drain_q);
			v_s2 <= v_s1 && able;
			v_s3 <= v_s2;
			if (start && state_q == S_IDLE) begin
				hit_q <= 1'b0;
			end else if (v_s3 && dsum < cgc_pkg::SUM_W'(thr_s3)) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Pipeline payload: tag, distance, squares
	always_ff @(posedge clk) begin
		ent_s1    <= (state_q == S_ENT);
		cx_s1     <= cx_q;
		cy_s1     <= cy_q;
		dxa_s2    <= cgc_pkg::mag_of(ent_s1 ? dxe : dxt);
		dya_s2    <= cgc_pkg::mag_of(ent_s1 ? dye : dyt);
		md_s2     <= cgc_pkg::MD_W'(r_q) + cgc_pkg::MD_W'(ent_rdata.rad);
		use_md_s2 <= ent_s1;
		dx2_s3    <= dxa_s2 * dxa_s2;
		dy2_s3    <= dya_s2 * dya_s2;
		thr_s3    <= use_md_s2 ? (md_s2 * md_s2) : cgc_pkg::THR_W'(rr_q);
	end

	// A query starts only from idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == S_IDLE))
		else $error("query started while busy");

	// The result is held until taken
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ack) |=> (done && $stable(hit_q)))
		else $error("result dropped before taken");

	// The pipeline is empty when the result is shown
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(v_s1 || v_s2 || v_s3))
		else $error("result shown with checks in flight");

	// Entity reads stay below the slot count
	a_ent_range: assert property (@(posedge clk) disable iff (!arst_n)
		(issue_e && !drain_q) |-> (ei_q < nsat_q))
		else $error("entity read past slot count");

endmodule

[rtl/core/circle_tile_grid_collision_unit.sv]
// ----------------------------------------------------------------------------
// circle_tile_grid_collision_unit
// Circle versus tile map and entity table collision test.
// ----------------------------------------------------------------------------
// A query runs the setup states S_SET1 to S_SET4 to work out the search box,
// clamped to the map; then the tile memory and the entity memory are each
// read once per tile in the box or entity slot checked through their single
// read port, followed by a short drain of the distance pipeline. One item is
// in work at a time; a finished result waits in the output register while
// the next item is taken.
module circle_tile_grid_collision_unit #(
	parameter int MAP_DIM_MAX      = 64,
	parameter int MAX_ENTITY_SLOTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic [cgc_pkg::SLOT_W-1:0]        slot_index,
	input  logic [cgc_pkg::CODE_W-1:0]        tile_code,
	input  logic signed [cgc_pkg::POS_W-1:0]  pos_x,
	input  logic signed [cgc_pkg::POS_W-1:0]  pos_y,
	input  logic [cgc_pkg::RAD_W-1:0]         circle_radius,
	input  logic                              entity_active,
	input  logic                              entity_solid,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              is_solid,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                        cfg_data
);

	localparam int TILE_DEPTH = MAP_DIM_MAX * MAP_DIM_MAX;
	localparam int TA_W       = $clog2(TILE_DEPTH);
	localparam int EA_W       = (MAX_ENTITY_SLOTS > 1) ? $clog2(MAX_ENTITY_SLOTS) : 1;

	cgc_pkg::cfg_t cfg_q;
	logic          out_valid_q, is_solid_q;
	logic          accept, start, busy, done, hit, ack;
	logic          tile_we, ent_we;
	logic [TA_W-1:0]            tile_raddr;
	logic [cgc_pkg::CODE_W-1:0] tile_rdata;
	logic [EA_W-1:0]            ent_raddr;
	cgc_pkg::ent_t              ent_rdata, ent_wdata;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = busy;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign is_solid  = is_solid_q;
	assign ack       = !out_valid_q || !out_stall;

	// Decode the transaction mode
	always_comb begin
		start   = 1'b0;
		tile_we = 1'b0;
		ent_we  = 1'b0;
		unique case (mode)
			cgc_pkg::MODE_QUERY:  start   = accept;
			cgc_pkg::MODE_TILE:   tile_we = accept && (32'(slot_index) < 32'(TILE_DEPTH));
			cgc_pkg::MODE_ENTITY: ent_we  = accept && (32'(slot_index) < 32'(MAX_ENTITY_SLOTS));
			default: ;
		endcase
		ent_wdata.x      = pos_x;
		ent_wdata.y      = pos_y;
		ent_wdata.rad    = circle_radius;
		ent_wdata.active = entity_active;
		ent_wdata.solid  = entity_solid;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width    <= 7'd64;
			cfg_q.map_height   <= 7'd64;
			cfg_q.wall_code    <= 8'd1;
			cfg_q.door_code    <= 8'd2;
			cfg_q.entity_count <= 7'd0;
			cfg_q.box_pad      <= 8'd26;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cgc_pkg::CFG_MAP_WIDTH:  cfg_q.map_width    <= cfg_data[6:0];
				cgc_pkg::CFG_MAP_HEIGHT: cfg_q.map_height   <= cfg_data[6:0];
				cgc_pkg::CFG_WALL_CODE:  cfg_q.wall_code    <= cfg_data;
				cgc_pkg::CFG_DOOR_CODE:  cfg_q.door_code    <= cfg_data;
				cgc_pkg::CFG_ENT_COUNT:  cfg_q.entity_count <= cfg_data[6:0];
				cgc_pkg::CFG_MARGIN:     cfg_q.box_pad      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output register: load a finished result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && ack) begin
			is_solid_q <= hit;
		end
	end

	cgc_tile_mem #(
		.DEPTH (TILE_DEPTH),
		.AW    (TA_W)
	) u_tile_mem (
		.clk   (clk),
		.we    (tile_we),
		.waddr (TA_W'(slot_index)),
		.wdata (tile_code),
		.raddr (tile_raddr),
		.rdata (tile_rdata)
	);

	cgc_ent_mem #(
		.DEPTH (MAX_ENTITY_SLOTS),
		.AW    (EA_W)
	) u_ent_mem (
		.clk   (clk),
		.we    (ent_we),
		.waddr (EA_W'(slot_index)),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	cgc_query #(
		.MAP_DIM_MAX      (MAP_DIM_MAX),
		.MAX_ENTITY_SLOTS (MAX_ENTITY_SLOTS)
	) u_query (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.qx         (pos_x),
		.qy         (pos_y),
		.qr         (circle_radius),
		.busy       (busy),
		.done       (done),
		.hit        (hit),
		.ack        (ack),
		.tile_raddr (tile_raddr),
		.tile_rdata (tile_rdata),
		.ent_raddr  (ent_raddr),
		.ent_rdata  (ent_rdata)
	);

endmodule
